// ----- rtl/mews_pkg.sv -----
package mews_pkg;

    localparam int FINGERS             = 5;
    localparam int READINGS_PER_FINGER = 24;
    localparam int NUM_CHANNELS        = FINGERS * READINGS_PER_FINGER;

    localparam int CH_W    = 7;
    localparam int DATA_W  = 16;
    localparam int ALPHA_W = 17;
    localparam int FRAC_W  = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd16384;

    typedef logic [CH_W-1:0]          channel_t;
    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [ALPHA_W-1:0]       alpha_t;

endpackage

// ----- rtl/mews_blend.sv -----
module mews_blend
(
    input  mews_pkg::sample_t newer,
    input  mews_pkg::sample_t older,
    input  mews_pkg::alpha_t  alpha,
    output mews_pkg::sample_t result
);

    // alpha*new + (1-alpha)*old == old + alpha*(new-old), scaled by 2^16
    logic signed [mews_pkg::DATA_W:0]    diff;
    logic signed [mews_pkg::ALPHA_W:0]   alpha_s;
    logic signed [mews_pkg::DATA_W+mews_pkg::ALPHA_W+1:0] prod;
    logic signed [mews_pkg::DATA_W+mews_pkg::ALPHA_W+1:0] acc;
    logic signed [mews_pkg::DATA_W+mews_pkg::ALPHA_W+1:0] quot;

    always_comb
    begin
        diff    = {newer[mews_pkg::DATA_W-1], newer} - {older[mews_pkg::DATA_W-1], older};
        alpha_s = {1'b0, alpha};
        prod    = (mews_pkg::DATA_W+mews_pkg::ALPHA_W+2)'(alpha_s)
                * (mews_pkg::DATA_W+mews_pkg::ALPHA_W+2)'(diff);
        acc     = ((mews_pkg::DATA_W+mews_pkg::ALPHA_W+2)'(older) <<< mews_pkg::FRAC_W) + prod;
        quot    = acc >>> mews_pkg::FRAC_W;
        // arithmetic shift floors; bump negatives with a remainder to truncate toward zero
        if (acc[mews_pkg::DATA_W+mews_pkg::ALPHA_W+1] && (acc[mews_pkg::FRAC_W-1:0] != '0))
        begin
            quot = quot + (mews_pkg::DATA_W+mews_pkg::ALPHA_W+2)'(1);
        end
        result = quot[mews_pkg::DATA_W-1:0];
    end

endmodule

// ----- rtl/multichannel_ewma_smoother_core.sv -----
// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_stall  channel[6:0], sample[15:0] signed
// out      out  out_valid / out_stall out_channel[6:0], smoothed[15:0] signed
// cfg      in   cfg_valid / cfg_ready alpha_weight[16:0]
//
// One word per cycle sustained while out_stall is low; out_valid is registered after s1.
// The per-channel store is a 120 x 16 RAM read at accept and written as s1 fires;
// a back-to-back hit on the same channel takes the last written value instead.
// Reset clears the seen bits (flops), out_valid and sets alpha_reg to 0.25; no sweep.
// out_stall backs up through the update stage into in_stall in the same cycle.
module multichannel_ewma_smoother_core
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  mews_pkg::channel_t        channel,
    input  mews_pkg::sample_t         sample,

    output logic                      out_valid,
    input  logic                      out_stall,
    output mews_pkg::channel_t        out_channel,
    output mews_pkg::sample_t         smoothed,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  mews_pkg::alpha_t          alpha_weight
);

    mews_pkg::sample_t  mem [0:mews_pkg::NUM_CHANNELS-1];
    mews_pkg::sample_t  ram_q_reg;

    logic [mews_pkg::NUM_CHANNELS-1:0] seen_reg;
    mews_pkg::alpha_t   alpha_reg;

    logic               s1_valid_reg;
    mews_pkg::channel_t s1_ch_reg;
    mews_pkg::sample_t  s1_sample_reg;

    logic               wr_valid_reg;
    mews_pkg::channel_t wr_ch_reg;
    mews_pkg::sample_t  wr_data_reg;

    logic               out_valid_reg;
    mews_pkg::channel_t out_ch_reg;
    mews_pkg::sample_t  out_data_reg;

    logic               in_fire;
    logic               out_free;
    logic               s1_fire;
    logic               in_range;
    logic               in_range_rd;
    logic               seen_hit;
    mews_pkg::sample_t  old_val;
    mews_pkg::sample_t  blend_val;
    mews_pkg::sample_t  s1_result;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign in_range_rd = (32'(channel) < mews_pkg::NUM_CHANNELS);
    assign in_range    = (32'(s1_ch_reg) < mews_pkg::NUM_CHANNELS);
    assign seen_hit    = in_range ? seen_reg[s1_ch_reg] : 1'b0;

    // RAM read at accept may miss the write landing on the same edge
    assign old_val = (wr_valid_reg && (wr_ch_reg == s1_ch_reg)) ? wr_data_reg : ram_q_reg;

    mews_blend u_blend
    (
        .newer  (s1_sample_reg),
        .older  (old_val),
        .alpha  (alpha_reg),
        .result (blend_val)
    );

    assign s1_result = seen_hit ? blend_val : s1_sample_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && in_range_rd)
        begin
            ram_q_reg <= mem[channel];
        end
        if (s1_fire && in_range)
        begin
            mem[s1_ch_reg] <= s1_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ch_reg     <= channel;
            s1_sample_reg <= sample;
        end
        if (s1_fire)
        begin
            out_ch_reg   <= s1_ch_reg;
            out_data_reg <= s1_result;
        end
        if (s1_fire && in_range)
        begin
            wr_ch_reg   <= s1_ch_reg;
            wr_data_reg <= s1_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= mews_pkg::ALPHA_RESET;
            seen_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                alpha_reg <= (alpha_weight > mews_pkg::ALPHA_ONE) ? mews_pkg::ALPHA_ONE
                                                                  : alpha_weight;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire && in_range)
            begin
                seen_reg[s1_ch_reg] <= 1'b1;
                wr_valid_reg        <= 1'b1;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign smoothed    = out_data_reg;

endmodule
